// ===== sv/cletok_pkg.sv =====
package cletok_pkg;

   typedef logic [1:0] action_type;
   typedef logic [7:0] char_type;
   typedef logic [5:0] index_type;
   typedef logic [2:0] resp_type;
   typedef logic [6:0] byte7_type;
   typedef logic [3:0] count_type;
   typedef logic [5:0] length_type;

   // request actions
   localparam action_type ACT_CHAR  = 2'd0;
   localparam action_type ACT_MARK  = 2'd1;
   localparam action_type ACT_CLEAR = 2'd2;
   localparam action_type ACT_READ  = 2'd3;

   // response codes
   localparam resp_type RSP_NONE  = 3'd0;
   localparam resp_type RSP_EMPTY = 3'd1;
   localparam resp_type RSP_ECHO  = 3'd2;
   localparam resp_type RSP_ERASE = 3'd3;
   localparam resp_type RSP_FULL  = 3'd4;
   localparam resp_type RSP_ARGOV = 3'd5;

   // terminal bytes
   localparam char_type CH_BKSP  = 8'h7F;
   localparam char_type CH_ENTER = 8'h0D;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_LAST  = 8'h7E;

   localparam byte7_type SEP_CODE = 7'h00;

   typedef struct packed {
      resp_type   response;
      byte7_type  echo_char;
      logic       command_ready;
      count_type  arg_count;
      length_type line_length;
      byte7_type  read_byte;
      length_type arg_offset;
   } rsp_beat_type;

endpackage

// ===== sv/cletok_if.sv =====
interface cletok_req_if import cletok_pkg::*; ();
   logic       valid;
   logic       ready;
   action_type action;
   char_type   char_code;
   index_type  read_index;

   modport source (output valid, output action, output char_code, output read_index,
                   input ready);
   modport sink   (input valid, input action, input char_code, input read_index,
                   output ready);
endinterface

interface cletok_rsp_if import cletok_pkg::*; ();
   logic       valid;
   logic       ready;
   resp_type   response;
   byte7_type  echo_char;
   logic       command_ready;
   count_type  arg_count;
   length_type line_length;
   byte7_type  read_byte;
   length_type arg_offset;

   modport source (output valid, output response, output echo_char, output command_ready,
                   output arg_count, output line_length, output read_byte,
                   output arg_offset, input ready);
   modport sink   (input valid, input response, input echo_char, input command_ready,
                   input arg_count, input line_length, input read_byte,
                   input arg_offset, output ready);
endinterface

// ===== sv/command_line_editor_tokenizer_top.sv =====
// A request beat accepted is registered in the read stage, then in the output register that
// drives its response beat. Throughput: one beat per cycle while the sink is not stalling; the
// line store read-modify-write handles each byte as it is accepted. A two-entry output path
// (read stage plus output register) lets one more request in while a response waits.
// Reset: synchronous, clears pointers, counts, flags and both pipeline valids; the memories
// are not swept -- reads are masked by the fill counts, so no clearing pass is needed.
module command_line_editor_tokenizer_top
   import cletok_pkg::*;
#(
   parameter int BUFFER_LEN = 64,
   parameter int MAX_ARGS   = 10
) (
   input logic           clock,
   input logic           reset,
   cletok_req_if.sink    req_chan,
   cletok_rsp_if.source  rsp_chan
);

   // address and count widths
   localparam int AW  = $clog2(BUFFER_LEN);
   localparam int CW  = $clog2(MAX_ARGS + 1);
   localparam int AAW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
   localparam int XW0 = (AW > 6) ? AW : 6;
   localparam int XW  = ((XW0 > CW) ? XW0 : CW) + 1;

   localparam logic [AW-1:0] LAST_POS = AW'(BUFFER_LEN - 1);
   localparam logic [CW-1:0] ARG_LIM  = CW'(MAX_ARGS);

   // stage-1 record: response fields known at accept, plus read masks
   typedef struct packed {
      resp_type   response;
      byte7_type  echo_char;
      logic       command_ready;
      count_type  arg_count;
      length_type line_length;
      logic       byte_ok;
      logic       offs_ok;
   } stage_type;

   // line store and argument start table: one write port, synchronous reads
   logic [6:0]    store_mem [BUFFER_LEN];
   logic [AW-1:0] arg_mem   [MAX_ARGS];

   // editor state
   logic [AW-1:0] wp_ff, wp_in;
   logic [CW-1:0] args_ff, args_in;
   logic          pend_ff, pend_in;
   logic          sep_ff, sep_in;       // entry at wp-1 is a separator

   // memory read data
   logic [6:0]    store_prev_ff;        // entry at wp-2, refreshed every cycle
   logic [6:0]    store_rd_ff;
   logic [AW-1:0] arg_rd_ff;

   // pipeline
   logic         s1_valid_ff;
   stage_type    s1_ff, s1_in;
   logic         out_valid_ff;
   rsp_beat_type out_ff, out_in;

   logic accept, out_free, s1_move;

   // step decode
   logic          is_print, at_start, word_edge, drop, do_clear;
   logic          st_we, ag_we;
   logic [6:0]    st_wdata;
   logic [AW-1:0] wp_dec, prev_addr, st_raddr;
   logic [AAW-1:0] ag_raddr;
   logic [XW-1:0] idx_x, args_in_x, wp_in_x, arg_rd_x;
   resp_type      resp_code;
   byte7_type     echo_code;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign s1_move        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_print  = (req_chan.char_code >= CH_SPACE) && (req_chan.char_code <= CH_LAST);
   assign at_start  = (wp_ff == '0);
   assign word_edge = at_start || sep_ff;
   assign wp_dec    = wp_ff - AW'(1);

   assign idx_x    = XW'(req_chan.read_index);
   assign st_raddr = idx_x[AW-1:0];
   assign ag_raddr = idx_x[AAW-1:0];

   // editor step: decide response, next pointers and the store write
   always_comb begin
      wp_in     = wp_ff;
      args_in   = args_ff;
      pend_in   = pend_ff;
      sep_in    = sep_ff;
      resp_code = RSP_NONE;
      echo_code = '0;
      st_we     = 1'b0;
      st_wdata  = req_chan.char_code[6:0];
      ag_we     = 1'b0;
      drop      = 1'b0;
      do_clear  = 1'b0;
      if (accept) begin
         case (req_chan.action)
            ACT_CHAR: begin
               if (pend_ff) begin
                  resp_code = RSP_EMPTY;
               end else if (req_chan.char_code == CH_ENTER) begin
                  // entry at wp reads as a separator, masked by the fill count: only raise the flag
                  pend_in   = 1'b1;
                  resp_code = RSP_EMPTY;
               end else if (req_chan.char_code == CH_BKSP) begin
                  if (!at_start) begin
                     wp_in     = wp_dec;
                     sep_in    = (wp_dec != '0) && (store_prev_ff == SEP_CODE);
                     drop      = (wp_dec == '0) || (store_prev_ff == SEP_CODE);
                     resp_code = RSP_ERASE;
                  end else begin
                     drop      = 1'b1;
                     resp_code = RSP_EMPTY;
                  end
                  if (drop && (args_ff != '0)) begin
                     args_in = args_ff - CW'(1);
                  end
               end else if (is_print) begin
                  if (wp_ff >= LAST_POS) begin
                     do_clear  = 1'b1;
                     resp_code = RSP_FULL;
                  end else if ((req_chan.char_code == CH_SPACE) && word_edge) begin
                     // drop leading or doubled space, still echo it
                     echo_code = req_chan.char_code[6:0];
                     resp_code = RSP_ECHO;
                  end else if (word_edge && (args_ff >= ARG_LIM)) begin
                     do_clear  = 1'b1;
                     resp_code = RSP_ARGOV;
                  end else begin
                     if (word_edge) begin
                        ag_we   = 1'b1;
                        args_in = args_ff + CW'(1);
                     end
                     st_we     = 1'b1;
                     st_wdata  = (req_chan.char_code == CH_SPACE) ? SEP_CODE
                                                                  : req_chan.char_code[6:0];
                     wp_in     = wp_ff + AW'(1);
                     sep_in    = (req_chan.char_code == CH_SPACE);
                     echo_code = req_chan.char_code[6:0];
                     resp_code = RSP_ECHO;
                  end
               end
            end
            ACT_MARK: begin
               pend_in = 1'b0;
            end
            ACT_CLEAR: begin
               do_clear = 1'b1;
            end
            ACT_READ: begin
            end
            default: begin
            end
         endcase
      end
      if (do_clear) begin
         wp_in   = '0;
         args_in = '0;
         pend_in = 1'b0;
         sep_in  = 1'b0;
      end
   end

   // look ahead: fetch the entry two below the next write position for a later backspace
   assign prev_addr = wp_in - AW'(2);

   assign args_in_x = XW'(args_in);
   assign wp_in_x   = XW'(wp_in);

   always_comb begin
      s1_in.response      = resp_code;
      s1_in.echo_char     = echo_code;
      s1_in.command_ready = pend_in;
      s1_in.arg_count     = args_in_x[3:0];
      s1_in.line_length   = wp_in_x[5:0];
      // entries at or above the fill counts read as zero
      s1_in.byte_ok       = (req_chan.action == ACT_READ) && (idx_x < XW'(wp_ff));
      s1_in.offs_ok       = (req_chan.action == ACT_READ) && (idx_x < XW'(args_ff));
   end

   assign arg_rd_x = XW'(arg_rd_ff);

   always_comb begin
      out_in.response      = s1_ff.response;
      out_in.echo_char     = s1_ff.echo_char;
      out_in.command_ready = s1_ff.command_ready;
      out_in.arg_count     = s1_ff.arg_count;
      out_in.line_length   = s1_ff.line_length;
      out_in.read_byte     = s1_ff.byte_ok ? store_rd_ff : '0;
      out_in.arg_offset    = s1_ff.offs_ok ? arg_rd_x[5:0] : '0;
   end

   // memories: write on append / new argument, read every cycle (look-ahead) or on accept
   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[wp_ff] <= st_wdata;
      end
      store_prev_ff <= store_mem[prev_addr];
      if (accept) begin
         store_rd_ff <= store_mem[st_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ag_we) begin
         arg_mem[args_ff[AAW-1:0]] <= wp_ff;
      end
      if (accept) begin
         arg_rd_ff <= arg_mem[ag_raddr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         args_ff      <= '0;
         pend_ff      <= 1'b0;
         sep_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         args_ff <= args_in;
         pend_ff <= pend_in;
         sep_ff  <= sep_in;
         if (req_chan.ready) begin
            s1_valid_ff <= accept;
         end
         if (out_free) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   // payload: hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.response      = out_ff.response;
   assign rsp_chan.echo_char     = out_ff.echo_char;
   assign rsp_chan.command_ready = out_ff.command_ready;
   assign rsp_chan.arg_count     = out_ff.arg_count;
   assign rsp_chan.line_length   = out_ff.line_length;
   assign rsp_chan.read_byte     = out_ff.read_byte;
   assign rsp_chan.arg_offset    = out_ff.arg_offset;

endmodule

// ===== bench/tb_command_line_editor_tokenizer_top.sv =====
module tb_command_line_editor_tokenizer_top
   import cletok_pkg::*;
();

   localparam int LINE_DEPTH  = 64;
   localparam int ARG_SLOTS   = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Free-running clock, period 12.
   always #6 clock = ~clock;

   cletok_req_if req_chan();
   cletok_rsp_if rsp_chan();

   command_line_editor_tokenizer_top #(
      .BUFFER_LEN(LINE_DEPTH),
      .MAX_ARGS  (ARG_SLOTS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // ------------------------------------------------------------------
   // Shadow copy of the editor: line store, argument starts, fill counts.
   // ------------------------------------------------------------------
   byte7_type  shadow_line [LINE_DEPTH];
   length_type shadow_args [ARG_SLOTS];
   int         shadow_wpos;
   int         shadow_nargs;
   logic       shadow_pending;

   rsp_beat_type editor_replies [$];   // responses still owed by the block

   int sent_count    = 0;   // request beats accepted
   int replies_seen  = 0;   // response beats accepted
   int mismatches    = 0;
   int cycle_count   = 0;

   // Traffic shaping shared by both sides. idle_on is set directly by the test
   // sequence; the hold-off controls go through NBAs.
   logic idle_on    = 1'b1;
   int   hold_len   = 0;
   int   hold_token = 0;
   int   hold_seen  = 0;
   int   sink_wait  = 0;

   function automatic void wipe_shadow();
      for (int i = 0; i < LINE_DEPTH; i++) shadow_line[i] = SEP_CODE;
      for (int i = 0; i < ARG_SLOTS; i++) shadow_args[i] = '0;
      shadow_wpos    = 0;
      shadow_nargs   = 0;
      shadow_pending = 1'b0;
   endfunction

   // Advance the shadow editor by one request and return the response it owes.
   function automatic rsp_beat_type predict_editor(action_type act, char_type ch,
                                                   index_type idx);
      rsp_beat_type r;
      logic at_start;
      logic after_sep;
      logic sep_before;
      logic overflow;
      r = '0;
      case (act)
         ACT_CHAR: begin
            if (shadow_pending) begin
               // line is waiting to be consumed: swallow the byte
               r.response = RSP_EMPTY;
            end else if (ch == CH_ENTER) begin
               shadow_line[shadow_wpos] = SEP_CODE;
               shadow_pending = 1'b1;
               r.response = RSP_EMPTY;
            end else if (ch == CH_BKSP) begin
               sep_before = 1'b0;
               if (shadow_wpos > 0) begin
                  shadow_wpos--;
                  shadow_line[shadow_wpos] = SEP_CODE;
                  if (shadow_wpos > 0)
                     sep_before = (shadow_line[shadow_wpos-1] == SEP_CODE);
                  r.response = RSP_ERASE;
               end else begin
                  r.response = RSP_EMPTY;
               end
               // the removed character began an argument: drop that argument
               if ((shadow_wpos == 0 || sep_before) && shadow_nargs > 0) begin
                  shadow_nargs--;
                  shadow_args[shadow_nargs] = '0;
               end
            end else if (ch >= CH_SPACE && ch <= CH_LAST) begin
               at_start  = (shadow_wpos == 0);
               after_sep = !at_start && (shadow_line[shadow_wpos-1] == SEP_CODE);
               if (shadow_wpos >= LINE_DEPTH - 1) begin
                  wipe_shadow();
                  r.response = RSP_FULL;
               end else if (ch == CH_SPACE && (at_start || after_sep)) begin
                  // leading or doubled space: echo it, store nothing
                  r.response  = RSP_ECHO;
                  r.echo_char = ch[6:0];
               end else begin
                  overflow = 1'b0;
                  if (at_start || after_sep) begin
                     if (shadow_nargs >= ARG_SLOTS) begin
                        wipe_shadow();
                        r.response = RSP_ARGOV;
                        overflow = 1'b1;
                     end else begin
                        shadow_args[shadow_nargs] = length_type'(shadow_wpos);
                        shadow_nargs++;
                     end
                  end
                  if (!overflow) begin
                     shadow_line[shadow_wpos] = (ch == CH_SPACE) ? SEP_CODE : ch[6:0];
                     shadow_wpos++;
                     r.response  = RSP_ECHO;
                     r.echo_char = ch[6:0];
                  end
               end
            end else begin
               r.response = RSP_NONE;
            end
         end
         ACT_MARK:  shadow_pending = 1'b0;
         ACT_CLEAR: wipe_shadow();
         default: begin
            r.read_byte = shadow_line[idx];
            if (idx < ARG_SLOTS) r.arg_offset = shadow_args[idx];
         end
      endcase
      r.command_ready = shadow_pending;
      r.arg_count     = count_type'(shadow_nargs);
      r.line_length   = length_type'(shadow_wpos);
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got, int beat_no);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on response beat %0d, %s: expected %0d, got %0d",
                     beat_no, name, want, got);
      end
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------
   // Watch both channels. Check the response side first: a beat leaving
   // at this edge always belongs to a request taken at an earlier edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_beats
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset) begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.response      = rsp_chan.response;
            got.echo_char     = rsp_chan.echo_char;
            got.command_ready = rsp_chan.command_ready;
            got.arg_count     = rsp_chan.arg_count;
            got.line_length   = rsp_chan.line_length;
            got.read_byte     = rsp_chan.read_byte;
            got.arg_offset    = rsp_chan.arg_offset;
            replies_seen++;
            if (editor_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response beat %0d arrived with nothing outstanding", replies_seen);
            end else begin
               want = editor_replies.pop_front();
               check_field("response", want.response, got.response, replies_seen);
               check_field("echo_char", want.echo_char, got.echo_char, replies_seen);
               check_field("command_ready", want.command_ready, got.command_ready,
                           replies_seen);
               check_field("arg_count", want.arg_count, got.arg_count, replies_seen);
               check_field("line_length", want.line_length, got.line_length, replies_seen);
               check_field("read_byte", want.read_byte, got.read_byte, replies_seen);
               check_field("arg_offset", want.arg_offset, got.arg_offset, replies_seen);
            end
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            editor_replies.push_back(predict_editor(req_chan.action, req_chan.char_code,
                                                    req_chan.read_index));
      end
   end

   // ------------------------------------------------------------------
   // Response sink: random stalls, plus a long hold-off on request.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : sink_side
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         sink_wait = 0;
      end else if (hold_token != hold_seen) begin
         // start a long hold-off, counted down cycle by cycle
         hold_seen = hold_token;
         sink_wait = hold_len;
         rsp_chan.ready <= 1'b0;
      end else if (sink_wait > 0) begin
         sink_wait--;
         rsp_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
         sink_wait = pick_gap();
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Watchdog: drop out if the run hangs.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one request beat and hold it until taken. Valid stays high across
   // back-to-back beats; it drops only for a gap or a drain.
   task automatic send_beat(input action_type act, input char_type ch, input index_type idx);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.char_code  <= ch;
      req_chan.read_index <= idx;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      sent_count++;
   endtask

   // Terminal byte; scramble the unused index so its bits keep moving.
   task automatic send_char(input char_type ch);
      send_beat(ACT_CHAR, ch, index_type'($urandom_range(0, 63)));
   endtask

   task automatic send_read(input index_type idx);
      send_beat(ACT_READ, char_type'($urandom_range(0, 255)), idx);
   endtask

   task automatic send_word_char();
      send_char(char_type'($urandom_range(8'h21, 8'h7E)));
   endtask

   // Pause the sender until every owed response has come back.
   task automatic wait_for_replies();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (replies_seen < sent_count);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Field extremes, every action and the edge cases of the editor.
   task automatic test_directed();
      send_read(6'd0);
      send_beat(ACT_READ, 8'hFF, 6'd63);
      send_char(CH_BKSP);                 // backspace on an empty line
      send_char(CH_SPACE);                // leading space, echoed only
      send_char(8'h61);
      send_char(CH_SPACE);                // separator
      send_char(CH_SPACE);                // doubled space, dropped
      send_char(CH_LAST);                 // highest printable starts argument two
      send_char(8'h00);                   // control codes and high bytes are ignored
      send_char(8'hFF);
      send_char(8'h80);
      send_read(6'd1);
      send_read(6'd9);
      send_char(CH_BKSP);                 // erases an argument's first char
      send_char(CH_BKSP);                 // erases the separator
      send_char(8'h21);
      send_char(CH_ENTER);
      send_char(8'h62);                   // byte while a command is pending
      send_char(CH_BKSP);                 // backspace while pending
      send_read(6'd0);
      send_beat(ACT_MARK, 8'hFF, 6'd63);
      send_char(8'h63);
      send_beat(ACT_CLEAR, 8'hAA, 6'd42);
      send_read(6'd2);
   endtask

   // Fill the store to its last slot, then overflow it with a char and with a space.
   task automatic test_store_full();
      for (int i = 0; i < LINE_DEPTH - 1; i++) send_word_char();
      send_read(6'd62);
      send_read(6'd63);
      send_word_char();
      for (int i = 0; i < LINE_DEPTH - 1; i++) send_word_char();
      send_char(CH_SPACE);
      send_read(6'd0);
   endtask

   // Fill the argument list, then start one argument too many.
   task automatic test_arg_overflow();
      for (int i = 0; i < ARG_SLOTS; i++) begin
         send_word_char();
         send_char(CH_SPACE);
      end
      send_read(index_type'(ARG_SLOTS - 1));
      send_read(index_type'(ARG_SLOTS));
      send_word_char();
      send_read(6'd0);
   endtask

   // Fully random beat: any action, any byte, any index.
   task automatic send_noise();
      send_beat(action_type'($urandom_range(0, 3)), char_type'($urandom_range(0, 255)),
                index_type'($urandom_range(0, 63)));
   endtask

   // Mostly well-formed lines of random words; some noise, backspaces and clears.
   task automatic type_random_lines(input int target);
      int start;
      int words;
      int wlen;
      int roll;
      start = sent_count;
      while (sent_count - start < target) begin
         if ($urandom_range(0, 9) == 0) begin
            send_noise();
            continue;
         end
         words = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
         if ($urandom_range(0, 3) == 0) send_char(CH_SPACE);
         for (int w = 0; w < words; w++) begin
            wlen = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(1, 6);
            for (int j = 0; j < wlen; j++) begin
               send_word_char();
               if ($urandom_range(0, 11) == 0) send_char(CH_BKSP);
            end
            send_char(CH_SPACE);
            if ($urandom_range(0, 3) == 0) send_char(CH_SPACE);
         end
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 4)) send_char(CH_BKSP);
         roll = $urandom_range(0, 9);
         if (roll < 8) begin
            send_char(CH_ENTER);
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 1) == 0) send_read(index_type'($urandom_range(0, 15)));
               else send_read(index_type'($urandom_range(0, 63)));
            end
            if ($urandom_range(0, 3) == 0) send_noise();
            send_beat(ACT_MARK, char_type'($urandom_range(0, 255)),
                      index_type'($urandom_range(0, 63)));
         end else if (roll == 8) begin
            send_beat(ACT_CLEAR, char_type'($urandom_range(0, 255)),
                      index_type'($urandom_range(0, 63)));
         end
      end
   endtask

   // Hold the sink off for a long stretch while requests keep coming back to back,
   // so the block fills and stalls its input; then drain.
   task automatic test_backpressure();
      idle_on    = 1'b0;
      hold_len   <= 250;
      hold_token <= hold_token + 1;
      type_random_lines(30);
      wait_for_replies();
      idle_on = 1'b1;
   endtask

   // A stretch with no idling on either side.
   task automatic test_no_idle();
      idle_on = 1'b0;
      type_random_lines(60);
      wait_for_replies();
      idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      req_chan.valid      = 1'b0;
      req_chan.action     = ACT_CHAR;
      req_chan.char_code  = '0;
      req_chan.read_index = '0;
      rsp_chan.ready      = 1'b0;
      wipe_shadow();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      wait_for_replies();
      test_store_full();
      test_arg_overflow();
      wait_for_replies();
      type_random_lines(120);
      test_backpressure();
      test_no_idle();

      // Drain, then let the pipeline settle before judging.
      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && editor_replies.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/cletok_pkg.sv
sv/cletok_if.sv
sv/command_line_editor_tokenizer_top.sv
bench/tb_command_line_editor_tokenizer_top.sv
